/* rtl/kae_pkg.sv */
// Shared types and constants for the key auto-repeat engine.
`timescale 1ns / 1ps
`default_nettype none

package kae_pkg;

   localparam int TIME_W    = 48;
   localparam int CODE_W    = 16;
   localparam int TIMING_W  = 24;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 24;
   localparam int SIZE_W    = 3;
   localparam int CNT_OUT_W = 4;

   // command codes
   localparam logic [1:0] CMD_PRESS   = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_POLL    = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DELAY    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTERVAL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SET_SIZE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_A    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_B    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_C    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_D    = 3'd6;

   // register reset values
   localparam logic [TIMING_W-1:0] DELAY_RESET    = 24'd500000;
   localparam logic [TIMING_W-1:0] INTERVAL_RESET = 24'd100000;
   localparam logic [SIZE_W-1:0]   SET_SIZE_RESET = 3'd4;
   // entry k is repeat key k: up, down, left, right arrows
   localparam logic [3:0][CODE_W-1:0] RKEY_RESET =
      {16'd106, 16'd105, 16'd108, 16'd103};

   typedef struct packed {
      logic [1:0]        command;
      logic [CODE_W-1:0] key_code;
      logic [TIME_W-1:0] time_now;
   } kae_req_type;

   typedef struct packed {
      logic                 event_valid;
      logic [CODE_W-1:0]    event_code;
      logic                 pressed;
      logic                 is_repeat;
      logic [TIME_W-1:0]    next_due;
      logic [CNT_OUT_W-1:0] held_count;
   } kae_rsp_type;

   typedef struct packed {
      logic lt;   // a < b
      logic le;   // a <= b
   } kae_cmp_type;

endpackage

`default_nettype wire

/* rtl/kae_time_unit.sv */
// Shared time unit: one 48-bit magnitude compare and one saturating add.
`timescale 1ns / 1ps
`default_nettype none

module kae_time_unit import kae_pkg::*; (
   input  wire logic [TIME_W-1:0]   cmp_a,
   input  wire logic [TIME_W-1:0]   cmp_b,
   input  wire logic [TIME_W-1:0]   add_a,
   input  wire logic [TIMING_W-1:0] add_b,
   output kae_cmp_type              cmp_res,
   output logic [TIME_W-1:0]        sum
);

   logic [TIME_W:0] raw_sum;

   always_comb begin
      cmp_res.lt = (cmp_a < cmp_b);
      cmp_res.le = (cmp_a <= cmp_b);
   end

   // saturate at all ones on carry out
   assign raw_sum = {1'b0, add_a} + {{(TIME_W + 1 - TIMING_W){1'b0}}, add_b};
   assign sum     = raw_sum[TIME_W] ? {TIME_W{1'b1}} : raw_sum[TIME_W-1:0];

endmodule

`default_nettype wire

/* rtl/key_autorepeat_engine_top.sv */
// Top level of the key auto-repeat engine: held-key table, sequencer, config.
// Each item runs a lookup scan, a table update step and a summary scan, one slot
// per cycle through the shared time unit and the table read port; a poll that fires
// a repeat adds a deadline catch-up step before the summary scan. A new item is
// taken only while idle; busy drops in the rsp_strobe cycle, so the next start
// lands on that edge.
// Reset (synchronous): table empty, registers at defaults; rsp_strobe cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module key_autorepeat_engine_top import kae_pkg::*; #(
   parameter int HELD_SLOTS  = 8,
   parameter int REPEAT_KEYS = 4
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // item beat
   input  wire logic                 start,
   output logic                      busy,
   input  wire kae_req_type          req_data,
   // result beat
   output logic                      rsp_strobe,
   output kae_rsp_type               rsp_data,
   // config write port
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   localparam int IDX_W = (HELD_SLOTS > 1) ? $clog2(HELD_SLOTS) : 1;
   localparam int CNT_W = $clog2(HELD_SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HELD_SLOTS - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;  // issue one table read a cycle
   localparam logic [2:0] S_DRAIN = 3'd2;  // last read in flight
   localparam logic [2:0] S_APPLY = 3'd3;  // table update / event fields
   localparam logic [2:0] S_POLL2 = 3'd4;  // repeat deadline catch-up
   localparam logic [2:0] S_DONE  = 3'd5;  // drive the result beat

   // ---------------------------------------------------------------------
   // State
   // ---------------------------------------------------------------------
   logic [2:0]           state_ff, state_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;           // read address
   logic                 proc_vld_ff, proc_vld_in; // read data valid
   logic [IDX_W-1:0]     proc_idx_ff, proc_idx_in; // slot of read data
   logic                 pass_ff, pass_in;         // 0 lookup scan, 1 summary scan

   logic [HELD_SLOTS-1:0] used_ff, used_in;
   logic [HELD_SLOTS-1:0] armed_ff, armed_in;

   logic                 found_ff, found_in;  // press: free slot, release: match
   logic                 hit_ff, hit_in;      // press: key already held
   logic                 have_ff, have_in;    // bound_ff holds a slot deadline
   logic [IDX_W-1:0]     tgt_ff, tgt_in;
   logic [TIME_W-1:0]    bound_ff, bound_in;  // best due / soonest deadline
   logic [TIME_W-1:0]    tmp_ff, tmp_in;
   logic [CODE_W-1:0]    best_code_ff, best_code_in;
   logic [CNT_W-1:0]     held_ff, held_in;

   logic [1:0]           cmd_ff, cmd_in;
   logic [CODE_W-1:0]    key_ff, key_in;
   logic [TIME_W-1:0]    now_ff, now_in;

   logic                 rsp_strobe_ff, rsp_strobe_in;
   kae_rsp_type          rsp_data_ff, rsp_data_in;

   // configuration registers
   logic [TIMING_W-1:0]  delay_ff, delay_in;
   logic [TIMING_W-1:0]  interval_ff, interval_in;
   logic [SIZE_W-1:0]    set_size_ff, set_size_in;
   logic [REPEAT_KEYS-1:0][CODE_W-1:0] rkey_ff, rkey_in;

   // slot table storage, one read and one write port
   logic [CODE_W-1:0]    code_mem [HELD_SLOTS];
   logic [TIME_W-1:0]    dl_mem   [HELD_SLOTS];
   logic [CODE_W-1:0]    code_rd_ff;
   logic [TIME_W-1:0]    dl_rd_ff;
   logic                 code_we, dl_we;
   logic [TIME_W-1:0]    dl_wr;

   // shared time unit hookup
   logic [TIME_W-1:0]    cmp_a, cmp_b, add_a, sum;
   logic [TIMING_W-1:0]  add_b;
   kae_cmp_type          cmp_res;

   logic                 rep_key;
   logic                 slot_u, slot_a, slot_match;
   logic [CSR_IDX_W-1:0] kidx;

   kae_time_unit u_time (
      .cmp_a   (cmp_a),
      .cmp_b   (cmp_b),
      .add_a   (add_a),
      .add_b   (add_b),
      .cmp_res (cmp_res),
      .sum     (sum)
   );

   // operand select: catch-up compares the advanced deadline against now,
   // every scan compares the slot deadline against the running bound
   always_comb begin
      cmp_a = (state_ff == S_POLL2) ? tmp_ff : dl_rd_ff;
      cmp_b = (state_ff == S_POLL2) ? now_ff : bound_ff;
      add_a = (state_ff == S_APPLY && cmd_ff == CMD_POLL) ? bound_ff : now_ff;
      add_b = (state_ff == S_APPLY && cmd_ff == CMD_PRESS) ? delay_ff : interval_ff;
   end

   // repeat-set membership of the captured key; none when delay or interval is zero
   always_comb begin
      rep_key = 1'b0;
      for (int k = 0; k < REPEAT_KEYS; k++) begin
         if (SIZE_W'(k) < set_size_ff && rkey_ff[k] == key_ff) begin
            rep_key = 1'b1;
         end
      end
      if (delay_ff == '0 || interval_ff == '0) begin
         rep_key = 1'b0;
      end
   end

   assign slot_u     = used_ff[proc_idx_ff];
   assign slot_a     = armed_ff[proc_idx_ff];
   assign slot_match = slot_u && (code_rd_ff == key_ff);
   assign kidx       = csr_index - REG_KEY_A;

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      proc_vld_in   = 1'b0;
      proc_idx_in   = idx_ff;
      pass_in       = pass_ff;
      used_in       = used_ff;
      armed_in      = armed_ff;
      found_in      = found_ff;
      hit_in        = hit_ff;
      have_in       = have_ff;
      tgt_in        = tgt_ff;
      bound_in      = bound_ff;
      tmp_in        = tmp_ff;
      best_code_in  = best_code_ff;
      held_in       = held_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      now_in        = now_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      code_we       = 1'b0;
      dl_we         = 1'b0;
      dl_wr         = sum;

      // per-slot work on the table data read in the previous cycle
      if (proc_vld_ff) begin
         if (!pass_ff) begin
            case (cmd_ff)
               CMD_PRESS: begin
                  if (slot_match) begin
                     hit_in = 1'b1;
                  end
                  if (!slot_u && !found_ff) begin
                     found_in = 1'b1;
                     tgt_in   = proc_idx_ff;
                  end
               end
               CMD_RELEASE: begin
                  if (slot_match && !found_ff) begin
                     found_in = 1'b1;
                     tgt_in   = proc_idx_ff;
                  end
               end
               CMD_POLL: begin
                  // bound starts at now: first due slot needs <=, later strict <
                  if (slot_u && slot_a && (have_ff ? cmp_res.lt : cmp_res.le)) begin
                     have_in      = 1'b1;
                     bound_in     = dl_rd_ff;
                     tgt_in       = proc_idx_ff;
                     best_code_in = code_rd_ff;
                  end
               end
               default: ;
            endcase
         end else begin
            held_in = held_ff + CNT_W'(slot_u);
            if (slot_u && slot_a && (!have_ff || cmp_res.lt)) begin
               have_in  = 1'b1;
               bound_in = dl_rd_ff;
            end
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd_in   = req_data.command;
               key_in   = req_data.key_code;
               now_in   = req_data.time_now;
               bound_in = req_data.time_now;
               idx_in   = '0;
               pass_in  = 1'b0;
               found_in = 1'b0;
               hit_in   = 1'b0;
               have_in  = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            proc_vld_in = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_DRAIN: begin
            state_in = pass_ff ? S_DONE : S_APPLY;
         end
         S_APPLY: begin
            rsp_data_in.event_valid = 1'b0;
            rsp_data_in.event_code  = '0;
            rsp_data_in.pressed     = 1'b0;
            rsp_data_in.is_repeat   = 1'b0;
            idx_in   = '0;
            pass_in  = 1'b1;
            have_in  = 1'b0;
            held_in  = '0;
            state_in = S_SCAN;
            case (cmd_ff)
               CMD_PRESS: begin
                  rsp_data_in.event_valid = 1'b1;
                  rsp_data_in.event_code  = key_ff;
                  rsp_data_in.pressed     = 1'b1;
                  if (!hit_ff && found_ff) begin
                     used_in[tgt_ff]  = 1'b1;
                     armed_in[tgt_ff] = rep_key;
                     code_we          = 1'b1;
                     dl_we            = 1'b1;
                  end
               end
               CMD_RELEASE: begin
                  rsp_data_in.event_valid = 1'b1;
                  rsp_data_in.event_code  = key_ff;
                  if (found_ff) begin
                     used_in[tgt_ff]  = 1'b0;
                     armed_in[tgt_ff] = 1'b0;
                  end
               end
               CMD_POLL: begin
                  if (have_ff) begin
                     rsp_data_in.event_valid = 1'b1;
                     rsp_data_in.event_code  = best_code_ff;
                     rsp_data_in.pressed     = 1'b1;
                     rsp_data_in.is_repeat   = 1'b1;
                     tmp_in   = sum;   // deadline + interval
                     state_in = S_POLL2;
                  end
               end
               default: ;
            endcase
         end
         S_POLL2: begin
            // still not after now: restart from now + interval
            dl_we    = 1'b1;
            dl_wr    = cmp_res.le ? sum : tmp_ff;
            idx_in   = '0;
            pass_in  = 1'b1;
            have_in  = 1'b0;
            held_in  = '0;
            state_in = S_SCAN;
         end
         S_DONE: begin
            rsp_data_in.next_due   = have_ff ? bound_ff : '0;
            rsp_data_in.held_count = CNT_OUT_W'(held_ff);
            rsp_strobe_in          = 1'b1;
            state_in               = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // configuration decode
   always_comb begin
      delay_in    = delay_ff;
      interval_in = interval_ff;
      set_size_in = set_size_ff;
      rkey_in     = rkey_ff;
      if (csr_we) begin
         unique case (csr_index) inside
            REG_DELAY:    delay_in    = csr_wdata[TIMING_W-1:0];
            REG_INTERVAL: interval_in = csr_wdata[TIMING_W-1:0];
            REG_SET_SIZE: set_size_in = csr_wdata[SIZE_W-1:0];
            REG_KEY_A, REG_KEY_B, REG_KEY_C, REG_KEY_D: begin
               for (int k = 0; k < REPEAT_KEYS; k++) begin
                  if (kidx == CSR_IDX_W'(k)) begin
                     rkey_in[k] = csr_wdata[CODE_W-1:0];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         proc_vld_ff   <= 1'b0;
         pass_ff       <= 1'b0;
         used_ff       <= '0;
         armed_ff      <= '0;
         found_ff      <= 1'b0;
         hit_ff        <= 1'b0;
         have_ff       <= 1'b0;
         held_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
         delay_ff      <= DELAY_RESET;
         interval_ff   <= INTERVAL_RESET;
         set_size_ff   <= SET_SIZE_RESET;
         for (int k = 0; k < REPEAT_KEYS; k++) begin
            rkey_ff[k] <= RKEY_RESET[k];
         end
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         proc_vld_ff   <= proc_vld_in;
         pass_ff       <= pass_in;
         used_ff       <= used_in;
         armed_ff      <= armed_in;
         found_ff      <= found_in;
         hit_ff        <= hit_in;
         have_ff       <= have_in;
         held_ff       <= held_in;
         rsp_strobe_ff <= rsp_strobe_in;
         delay_ff      <= delay_in;
         interval_ff   <= interval_in;
         set_size_ff   <= set_size_in;
         rkey_ff       <= rkey_in;
      end
   end

   always_ff @(posedge clock) begin
      proc_idx_ff  <= proc_idx_in;
      tgt_ff       <= tgt_in;
      bound_ff     <= bound_in;
      tmp_ff       <= tmp_in;
      best_code_ff <= best_code_in;
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      now_ff       <= now_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // slot table: registered read at the scan address
   always_ff @(posedge clock) begin
      code_rd_ff <= code_mem[idx_ff];
      dl_rd_ff   <= dl_mem[idx_ff];
      if (code_we) begin
         code_mem[tgt_ff] <= key_ff;
      end
      if (dl_we) begin
         dl_mem[tgt_ff] <= dl_wr;
      end
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted beat did not raise busy");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while sequencer still running");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_held_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (held_ff == CNT_W'($countones(used_ff))))
      else $error("held count disagrees with slot valid bits");

   a_armed_used: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DONE |-> ((armed_ff & ~used_ff) == '0))
      else $error("armed slot not in use");

endmodule

`default_nettype wire
